FILE: design/rsc_pkg.sv
package rsc_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_BASE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_BASE = 1'b1;

    localparam int BASE_W = 6;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    // character classes
    localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
    localparam logic [7:0] CHAR_UPPER_LO = 8'd65;
    localparam logic [7:0] CHAR_UPPER_HI = 8'd90;
    localparam logic [7:0] CHAR_LOWER_LO = 8'd97;
    localparam logic [7:0] CHAR_LOWER_HI = 8'd122;
    localparam logic [7:0] UPPER_OFFSET = 8'd55;
    localparam logic [7:0] LOWER_OFFSET = 8'd87;
    localparam logic [6:0] ASCII_ZERO = 7'd48;
    localparam logic [6:0] ASCII_LETTER_OFS = 7'd55;
    localparam logic [5:0] MAX_DECIMAL = 6'd9;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;

    // remainder store
    localparam int STORE_DEPTH = 32;
    localparam int STORE_ADDR_W = 5;
    localparam int COUNT_W = 6;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } in_item_t;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
    } out_item_t;

    typedef struct packed {
        logic [7:0] digit;
        logic       last;
    } fold_req_t;

    typedef enum logic [1:0] {
        ST_FOLD,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT_WR
    } back_state_t;

endpackage

FILE: design/rsc_front.sv
module rsc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rsc_pkg::in_item_t request,
    input  logic              take,
    output logic              head_valid,
    output rsc_pkg::fold_req_t head
);
    import rsc_pkg::*;

    fold_req_t           q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_take;
    fold_req_t           classified;

    // map a character to its digit value, other bytes pass raw
    always_comb
    begin
        classified.last = request.last_symbol;
        priority if (request.symbol >= CHAR_DIGIT_LO && request.symbol <= CHAR_DIGIT_HI)
        begin
            classified.digit = request.symbol - CHAR_DIGIT_LO;
        end
        else if (request.symbol >= CHAR_UPPER_LO && request.symbol <= CHAR_UPPER_HI)
        begin
            classified.digit = request.symbol - UPPER_OFFSET;
        end
        else if (request.symbol >= CHAR_LOWER_LO && request.symbol <= CHAR_LOWER_HI)
        begin
            classified.digit = request.symbol - LOWER_OFFSET;
        end
        else
        begin
            classified.digit = request.symbol;
        end
    end

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_take    = take && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_take && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/rsc_back.sv
module rsc_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rsc_pkg::BASE_W-1:0] src_base,
    input  logic [rsc_pkg::BASE_W-1:0] dst_base,
    input  logic                       head_valid,
    input  rsc_pkg::fold_req_t         head,
    output logic                       take,
    output logic                       empty,
    input  logic                       pop,
    output rsc_pkg::out_item_t         result
);
    import rsc_pkg::*;

    localparam int STEP_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int PROD_W = VALUE_WIDTH + BASE_W;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic [VALUE_WIDTH-1:0]  quo_reg;
    logic [VALUE_WIDTH-1:0]  quo_next;
    logic [BASE_W-1:0]       rem_reg;
    logic [BASE_W-1:0]       rem_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [COUNT_W-1:0]      cnt_reg;
    logic [COUNT_W-1:0]      cnt_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_item_t               result_reg;
    out_item_t               result_next;

    logic [BASE_W-1:0]       store_mem [STORE_DEPTH];
    logic [BASE_W-1:0]       rd_data_reg;
    logic                    store_we;
    logic [STORE_ADDR_W-1:0] store_waddr;
    logic [STORE_ADDR_W-1:0] store_raddr;

    logic [PROD_W-1:0]       product;
    logic [VALUE_WIDTH-1:0]  fold_sum;
    logic [BASE_W-1:0]       base_clamped;
    logic [BASE_W:0]         trial;
    logic                    trial_ge;
    logic [BASE_W-1:0]       rem_step;
    logic [VALUE_WIDTH-1:0]  quo_step;
    logic                    last_step;
    logic                    out_free;
    logic [6:0]              ascii_char;

    // horner fold, wraps at the value width
    assign product  = PROD_W'(acc_reg) * PROD_W'(src_base);
    assign fold_sum = product[VALUE_WIDTH-1:0] + VALUE_WIDTH'(head.digit);

    always_comb
    begin
        priority if (dst_base < BASE_MIN)
        begin
            base_clamped = BASE_MIN;
        end
        else if (dst_base > BASE_MAX)
        begin
            base_clamped = BASE_MAX;
        end
        else
        begin
            base_clamped = dst_base;
        end
    end

    // one restoring division step per cycle
    assign trial     = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial_ge  = (trial >= {1'b0, base_clamped});
    assign rem_step  = trial_ge ? BASE_W'(trial - {1'b0, base_clamped}) : trial[BASE_W-1:0];
    assign quo_step  = {quo_reg[VALUE_WIDTH-2:0], trial_ge};
    assign last_step = (step_reg == STEP_W'(VALUE_WIDTH - 1));

    assign out_free   = !out_valid_reg || pop;
    assign ascii_char = (rd_data_reg <= MAX_DECIMAL)
                        ? ASCII_ZERO + 7'(rd_data_reg)
                        : ASCII_LETTER_OFS + 7'(rd_data_reg);

    assign store_we    = (state_reg == ST_DIV) && last_step && !cnt_reg[COUNT_W-1];
    assign store_waddr = cnt_reg[STORE_ADDR_W-1:0];
    assign store_raddr = STORE_ADDR_W'(cnt_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FOLD:
            begin
                if (head_valid && head.last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (last_step && quo_step == '0)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    state_next = (cnt_reg == COUNT_W'(1)) ? ST_FOLD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_FOLD;
            end
        endcase
    end

    always_comb
    begin
        take           = 1'b0;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            ST_FOLD:
            begin
                take = head_valid;
                if (head_valid)
                begin
                    if (head.last)
                    begin
                        acc_next  = '0;
                        quo_next  = fold_sum;
                        rem_next  = '0;
                        step_next = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        acc_next = fold_sum;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    // next digit restarts on the quotient with a clear remainder
                    rem_next  = '0;
                    step_next = '0;
                    if (!cnt_reg[COUNT_W-1])
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_EMIT_RD:
            begin
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    result_next.digit_char = ascii_char;
                    result_next.last_digit = (cnt_reg == COUNT_W'(1));
                    out_valid_next         = 1'b1;
                    cnt_next               = cnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= rem_step;
        end
        if (state_reg == ST_EMIT_RD)
        begin
            rd_data_reg <= store_mem[store_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FOLD;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/radix_string_converter.sv
// a request enters the 4-deep input queue and is folded into the value from the queue head,
// so plain characters are taken at one per cycle while no earlier string is being converted
// the last character starts a bit-serial restoring divider that yields one output digit per pass,
// then each digit is read from the remainder store and loaded into the output register
// reset clears the accumulator, queue, digit count and output valid; both bases return to 10
module radix_string_converter #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  rsc_pkg::in_item_t               request,
    output logic                            empty,
    input  logic                            pop,
    output rsc_pkg::out_item_t              result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsc_pkg::BASE_W-1:0]      cfg_data
);
    import rsc_pkg::*;

    logic [BASE_W-1:0] src_base_reg;
    logic [BASE_W-1:0] src_base_next;
    logic [BASE_W-1:0] dst_base_reg;
    logic [BASE_W-1:0] dst_base_next;
    logic              take;
    logic              head_valid;
    fold_req_t         head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        src_base_next = src_base_reg;
        dst_base_next = dst_base_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SRC_BASE: src_base_next = cfg_data;
                REG_DST_BASE: dst_base_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_base_reg <= BASE_RESET;
            dst_base_reg <= BASE_RESET;
        end
        else
        begin
            src_base_reg <= src_base_next;
            dst_base_reg <= dst_base_next;
        end
    end

    rsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .take       (take),
        .head_valid (head_valid),
        .head       (head)
    );

    rsc_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_base   (src_base_reg),
        .dst_base   (dst_base_reg),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule
